>>> rtl/form_urlencoded_pair_parser_top_defines.svh
// Assertion macros shared by the form-urlencoded pair parser RTL.
`ifndef FORM_URLENCODED_PAIR_PARSER_TOP_DEFINES_SVH
`define FORM_URLENCODED_PAIR_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled while reset is high.
`define FUP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fup assertion failed");

// Next-cycle implication, sampled on clock and disabled while reset is high.
`define FUP_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fup assertion failed");

`endif

>>> rtl/fup_pkg.sv
// Types, character constants and hex helpers for the form-urlencoded pair parser.
`default_nettype none

package fup_pkg;

   localparam int CH_W    = 8;
   localparam int EVT_MAX = 3;
   localparam int CNT_W   = 2;

   // Event codes on the result channel.
   typedef enum logic [2:0] {
      KIND_NAME    = 3'd0,
      KIND_VALUE   = 3'd1,
      KIND_RESTART = 3'd2,
      KIND_COMMIT  = 3'd3,
      KIND_DROP    = 3'd4
   } kind_type;

   // Held percent sequence progress.
   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_PCT   = 2'd1,
      PEND_DIGIT = 2'd2
   } pend_type;

   typedef struct packed {
      kind_type          kind;
      logic [CH_W-1:0]   data;
      logic              done;
   } evt_type;

   localparam logic [CH_W-1:0] CH_NUL      = 8'h00;
   localparam logic [CH_W-1:0] CH_AMP      = 8'h26;
   localparam logic [CH_W-1:0] CH_EQ       = 8'h3D;
   localparam logic [CH_W-1:0] CH_PCT      = 8'h25;
   localparam logic [CH_W-1:0] CH_PLUS     = 8'h2B;
   localparam logic [CH_W-1:0] CH_SPACE    = 8'h20;
   localparam logic [CH_W-1:0] CH_HEX_BIAS = 8'h57;
   localparam logic [CH_W-1:0] CH_DIG_LO   = 8'h30;
   localparam logic [CH_W-1:0] CH_DIG_HI   = 8'h39;
   localparam logic [CH_W-1:0] CH_LC_A     = 8'h61;
   localparam logic [CH_W-1:0] CH_LC_F     = 8'h66;
   localparam logic [CH_W-1:0] CH_UC_A     = 8'h41;
   localparam logic [CH_W-1:0] CH_UC_F     = 8'h46;
   localparam logic [CH_W-1:0] CH_CASE_BIT = 8'h20;

   // True for 0-9, a-f and A-F.
   function automatic logic is_hex(input logic [CH_W-1:0] c);
      return ((c >= CH_DIG_LO) && (c <= CH_DIG_HI)) ||
             ((c >= CH_LC_A) && (c <= CH_LC_F)) ||
             ((c >= CH_UC_A) && (c <= CH_UC_F));
   endfunction

   // Nibble value of a hex digit; letters fold to lower case first.
   function automatic logic [3:0] hex_val(input logic [CH_W-1:0] c);
      logic [CH_W-1:0] t;
      if ((c >= CH_DIG_LO) && (c <= CH_DIG_HI)) begin
         t = c - CH_DIG_LO;
      end else begin
         t = (c | CH_CASE_BIT) - CH_HEX_BIAS;
      end
      return t[3:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/fup_channels.sv
// Valid/ready channel interfaces for characters, events and the control register.
`default_nettype none

interface fup_req_if;
   logic                      valid;
   logic                      ready;
   logic [fup_pkg::CH_W-1:0]  ch;
   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

interface fup_rsp_if;
   logic                      valid;
   logic                      ready;
   fup_pkg::kind_type         kind;
   logic [fup_pkg::CH_W-1:0]  data_byte;
   logic                      string_done;
   logic                      last_of_run;
   modport source (output valid, output kind, output data_byte, output string_done,
                   output last_of_run, input ready);
   modport sink   (input valid, input kind, input data_byte, input string_done,
                   input last_of_run, output ready);
endinterface

interface fup_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/form_urlencoded_pair_parser_top.sv
// Form-urlencoded pair parser: splits name=value text and percent-decodes values.
//
// One character enters per beat on req_if and is held in an input register.
// There it is decoded against the parser state (name or value, held percent
// digits) into zero to three events, which load the event buffer once it is
// free; the buffer registers them and drives rsp_if one event per beat.
// Sustained rate is one character per cycle while each character yields at
// most one event and the sink takes every event; a character that yields
// two or three events (held percent bytes flushed at a segment end or by a
// broken percent sequence) occupies the single event port until all are
// taken, so input stalls meanwhile. The input register lets one further
// character be taken while an event waits on a stalled sink. The user must
// write the plus_as_space register through csr_if only while the parser is
// idle; the block does not enforce this. The register resets to 1.
`default_nettype none
`include "form_urlencoded_pair_parser_top_defines.svh"

module form_urlencoded_pair_parser_top (
   input  wire logic  clock,
   input  wire logic  reset,
   fup_req_if.sink    req_if,
   fup_rsp_if.source  rsp_if,
   fup_csr_if.sink    csr_if
);

   localparam int CW = fup_pkg::CH_W;
   localparam int NW = fup_pkg::CNT_W;

   // Registers.
   logic                       plus_ff,       plus_in;
   logic                       in_vld_ff,     in_vld_in;
   logic [CW-1:0]              in_ch_ff,      in_ch_in;
   logic                       in_value_ff,   in_value_in;
   fup_pkg::pend_type          pend_ff,       pend_in;
   logic [CW-1:0]              digit_ff,      digit_in;
   fup_pkg::evt_type           evt_ff [fup_pkg::EVT_MAX];
   fup_pkg::evt_type           evt_in [fup_pkg::EVT_MAX];
   logic [NW-1:0]              cnt_ff,        cnt_in;

   // Decoder outputs.
   fup_pkg::evt_type           dec_evt [fup_pkg::EVT_MAX];
   logic [NW-1:0]              dec_n;
   logic                       dec_in_value;
   fup_pkg::pend_type          dec_pend;
   logic [CW-1:0]              dec_digit;

   logic req_take;
   logic rsp_take;
   logic buf_free;
   logic load;

   // Handshakes: the buffer accepts a decoded character when empty or while its last event is taken.
   assign rsp_take = rsp_if.valid && rsp_if.ready;
   assign buf_free = (cnt_ff == '0) || ((cnt_ff == NW'(1)) && rsp_if.ready);
   assign load     = in_vld_ff && buf_free;
   assign req_if.ready = !in_vld_ff || load;
   assign req_take = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   // Result channel always shows the head of the event buffer.
   assign rsp_if.valid       = (cnt_ff != '0);
   assign rsp_if.kind        = evt_ff[0].kind;
   assign rsp_if.data_byte   = evt_ff[0].data;
   assign rsp_if.string_done = evt_ff[0].done;
   assign rsp_if.last_of_run = (cnt_ff == NW'(1));

   // Character decoder: builds the event list and the next parser state.
   always_comb begin
      logic [CW-1:0] c;
      logic          term;
      logic          flush;
      c            = in_ch_ff;
      term         = (c == fup_pkg::CH_NUL);
      flush        = 1'b0;
      dec_n        = '0;
      dec_in_value = in_value_ff;
      dec_pend     = pend_ff;
      dec_digit    = digit_ff;
      for (int i = 0; i < fup_pkg::EVT_MAX; i++) begin
         dec_evt[i] = '{kind: fup_pkg::KIND_NAME, data: '0, done: 1'b0};
      end

      if ((c == fup_pkg::CH_AMP) || term) begin
         // Segment end: commit a pair that saw '=', else drop the name.
         if (in_value_ff) begin
            flush = 1'b1;
         end
         dec_in_value = 1'b0;
         dec_pend     = fup_pkg::PEND_NONE;
         dec_digit    = '0;
      end else if (c == fup_pkg::CH_EQ) begin
         dec_in_value = 1'b1;
         dec_pend     = fup_pkg::PEND_NONE;
         dec_digit    = '0;
      end else if (in_value_ff) begin
         if ((pend_ff == fup_pkg::PEND_PCT) && fup_pkg::is_hex(c)) begin
            dec_pend  = fup_pkg::PEND_DIGIT;
            dec_digit = c;
         end else if ((pend_ff == fup_pkg::PEND_DIGIT) && fup_pkg::is_hex(c)) begin
            dec_pend  = fup_pkg::PEND_NONE;
            dec_digit = '0;
         end else begin
            flush     = 1'b1;
            dec_pend  = (c == fup_pkg::CH_PCT) ? fup_pkg::PEND_PCT : fup_pkg::PEND_NONE;
            dec_digit = '0;
         end
      end

      // Held percent bytes go out raw ahead of anything else.
      if (flush && (pend_ff != fup_pkg::PEND_NONE)) begin
         dec_evt[dec_n] = '{kind: fup_pkg::KIND_VALUE, data: fup_pkg::CH_PCT, done: 1'b0};
         dec_n = dec_n + NW'(1);
         if (pend_ff == fup_pkg::PEND_DIGIT) begin
            dec_evt[dec_n] = '{kind: fup_pkg::KIND_VALUE, data: digit_ff, done: 1'b0};
            dec_n = dec_n + NW'(1);
         end
      end

      // The event caused by the character itself.
      if ((c == fup_pkg::CH_AMP) || term) begin
         dec_evt[dec_n] = '{kind: in_value_ff ? fup_pkg::KIND_COMMIT : fup_pkg::KIND_DROP,
                            data: '0, done: term};
         dec_n = dec_n + NW'(1);
      end else if (c == fup_pkg::CH_EQ) begin
         dec_evt[dec_n] = '{kind: fup_pkg::KIND_RESTART, data: '0, done: 1'b0};
         dec_n = dec_n + NW'(1);
      end else if (!in_value_ff) begin
         dec_evt[dec_n] = '{kind: fup_pkg::KIND_NAME, data: c, done: 1'b0};
         dec_n = dec_n + NW'(1);
      end else if ((pend_ff == fup_pkg::PEND_DIGIT) && fup_pkg::is_hex(c)) begin
         dec_evt[dec_n] = '{kind: fup_pkg::KIND_VALUE,
                            data: {fup_pkg::hex_val(digit_ff), fup_pkg::hex_val(c)},
                            done: 1'b0};
         dec_n = dec_n + NW'(1);
      end else if (flush && (c != fup_pkg::CH_PCT)) begin
         dec_evt[dec_n] = '{kind: fup_pkg::KIND_VALUE,
                            data: (plus_ff && (c == fup_pkg::CH_PLUS)) ?
                                  fup_pkg::CH_SPACE : c,
                            done: 1'b0};
         dec_n = dec_n + NW'(1);
      end
   end

   // Next-state logic for the input register, parser state and event buffer.
   always_comb begin
      plus_in     = csr_if.valid ? csr_if.data : plus_ff;
      in_vld_in   = in_vld_ff;
      in_ch_in    = in_ch_ff;
      in_value_in = in_value_ff;
      pend_in     = pend_ff;
      digit_in    = digit_ff;
      cnt_in      = cnt_ff;
      for (int i = 0; i < fup_pkg::EVT_MAX; i++) begin
         evt_in[i] = evt_ff[i];
      end

      if (req_take) begin
         in_vld_in = 1'b1;
         in_ch_in  = req_if.ch;
      end else if (load) begin
         in_vld_in = 1'b0;
      end

      if (load) begin
         in_value_in = dec_in_value;
         pend_in     = dec_pend;
         digit_in    = dec_digit;
         cnt_in      = dec_n;
         for (int i = 0; i < fup_pkg::EVT_MAX; i++) begin
            evt_in[i] = dec_evt[i];
         end
      end else if (rsp_take) begin
         cnt_in = cnt_ff - NW'(1);
         for (int i = 0; i < fup_pkg::EVT_MAX - 1; i++) begin
            evt_in[i] = evt_ff[i+1];
         end
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         plus_ff     <= 1'b1;
         in_vld_ff   <= 1'b0;
         in_value_ff <= 1'b0;
         pend_ff     <= fup_pkg::PEND_NONE;
         digit_ff    <= '0;
         cnt_ff      <= '0;
      end else begin
         plus_ff     <= plus_in;
         in_vld_ff   <= in_vld_in;
         in_value_ff <= in_value_in;
         pend_ff     <= pend_in;
         digit_ff    <= digit_in;
         cnt_ff      <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_ch_ff <= in_ch_in;
      for (int i = 0; i < fup_pkg::EVT_MAX; i++) begin
         evt_ff[i] <= evt_in[i];
      end
   end

   // Held percent digits only exist while a value is being collected.
   `FUP_ASSERT_IMP(a_pend_in_value, pend_ff != fup_pkg::PEND_NONE, in_value_ff)
   // A closing event is always the last of its run and is a commit or a drop.
   `FUP_ASSERT_IMP(a_done_last, rsp_if.valid && rsp_if.string_done,
                   rsp_if.last_of_run && ((rsp_if.kind == fup_pkg::KIND_COMMIT) ||
                                          (rsp_if.kind == fup_pkg::KIND_DROP)))
   // A terminator leaves the parser collecting a fresh name with nothing held.
   `FUP_ASSERT_NXT(a_term_clears, load && (in_ch_ff == fup_pkg::CH_NUL),
                   !in_value_ff && (pend_ff == fup_pkg::PEND_NONE))
   // A stalled event buffer keeps its contents and count.
   `FUP_ASSERT_NXT(a_buf_hold, rsp_if.valid && !rsp_if.ready,
                   $stable(cnt_ff) && $stable(evt_ff[0]))

endmodule

`default_nettype wire
